// ----- rtl/rast_pkg.sv -----
// ----------------------------------------------------------------------------
// rast_pkg
// Shared types and constants of the depth-tested line rasterizer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rast_pkg;

  // screen bounds, fixed by the 6-bit pixel coordinates
  localparam int MAX_WIDTH  = 64;
  localparam int MAX_HEIGHT = 64;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 7;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_HEIGHT = 2'd1;

  // 0.2 in Q16.16
  localparam logic signed [33:0] DEPTH_SLACK = 34'sd13107;
  localparam logic [31:0] DEPTH_MIN = 32'h8000_0000;

  localparam int COORD_W = 7;
  localparam int DIV_W   = 33;

  typedef struct packed {
    logic signed [15:0] x_start;
    logic signed [15:0] y_start;
    logic signed [31:0] z_start;
    logic signed [15:0] x_end;
    logic signed [15:0] y_end;
    logic signed [31:0] z_end;
  } in_word_t;

  typedef struct packed {
    logic [5:0]         pixel_x;
    logic [5:0]         pixel_y;
    logic signed [31:0] pixel_depth;
    logic               written;
    logic               last;
  } out_word_t;

  typedef struct packed {
    logic [DIV_W-1:0]   quo;
    logic [COORD_W-1:0] rem;
    logic               done;
  } div_res_t;

endpackage

`default_nettype wire

// ----- rtl/rast_div.sv -----
// ----------------------------------------------------------------------------
// rast_div
// Restoring divider, one quotient bit per cycle, for the depth step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rast_div (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 start,
  input  wire [rast_pkg::DIV_W-1:0]           dividend,
  input  wire [rast_pkg::COORD_W-1:0]         divisor,
  output rast_pkg::div_res_t                  res
);

  localparam int CNT_W = $clog2(rast_pkg::DIV_W + 1);

  logic [CNT_W-1:0]                cnt_r;
  logic                            busy_r;
  logic                            done_r;
  logic [rast_pkg::COORD_W-1:0]    rem_r;
  logic [rast_pkg::COORD_W-1:0]    dvs_r;
  logic [rast_pkg::DIV_W-1:0]      quo_r;
  logic [rast_pkg::COORD_W:0]      trial;
  logic                            fits;

  assign trial = {rem_r, quo_r[rast_pkg::DIV_W-1]};
  assign fits  = trial >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(rast_pkg::DIV_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      dvs_r <= divisor;
      quo_r <= dividend;
    end else if (busy_r) begin
      rem_r <= fits ? rast_pkg::COORD_W'(trial - {1'b0, dvs_r})
                    : rast_pkg::COORD_W'(trial);
      quo_r <= {quo_r[rast_pkg::DIV_W-2:0], fits};
    end
  end

  assign res.quo  = quo_r;
  assign res.rem  = rem_r;
  assign res.done = done_r;

  assert property (@(posedge clk) disable iff (!rst_n) done_r |-> !busy_r)
    else $error("divider done while busy");

  assert property (@(posedge clk) disable iff (!rst_n) start |=> busy_r)
    else $error("divider not busy after start");

  assert property (@(posedge clk) disable iff (!rst_n) done_r |=> !done_r)
    else $error("divider done held longer than one cycle");

endmodule

`default_nettype wire

// ----- rtl/depth_tested_line_rasterizer.sv -----
// ----------------------------------------------------------------------------
// depth_tested_line_rasterizer
// Clamps and orders a line, steps it pixel by pixel and depth tests each
// pixel against an on-chip depth memory.
// ----------------------------------------------------------------------------
// channel | ports                          | direction
// in      | in_valid, in_ready, in_data    | line word in
// out     | out_valid, out_ready, out_data | pixel word out
// cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | register write
//
// after a line is taken it is oriented, the serial depth-step divider is
// awaited, then each pixel goes through the depth memory read, test/write,
// and the output word; a zero-length line returns to idle with no pixel word.
// after reset a clearing pass writes every memory entry, during which
// in_ready stays low; cfg writes are taken always.
// out_ready low holds the sequencer on the current pixel.
`timescale 1ns / 1ps
`default_nettype none

module depth_tested_line_rasterizer (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 in_valid,
  output logic                                in_ready,
  input  wire rast_pkg::in_word_t             in_data,
  output logic                                out_valid,
  input  wire                                 out_ready,
  output rast_pkg::out_word_t                 out_data,
  input  wire                                 cfg_valid,
  output logic                                cfg_ready,
  input  wire [rast_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire [rast_pkg::CFG_DAT_W-1:0]       cfg_data
);

  localparam int MAX_WIDTH  = rast_pkg::MAX_WIDTH;
  localparam int MAX_HEIGHT = rast_pkg::MAX_HEIGHT;
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = rast_pkg::COORD_W;

  localparam logic [2:0] ST_CLR    = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_ORIENT = 3'd2;
  localparam logic [2:0] ST_DIV    = 3'd3;
  localparam logic [2:0] ST_FIX    = 3'd4;
  localparam logic [2:0] ST_RD     = 3'd5;
  localparam logic [2:0] ST_CMP    = 3'd6;
  localparam logic [2:0] ST_OUT    = 3'd7;

  logic [2:0]               state_r, state_nxt;
  logic [AW-1:0]            clr_r;
  logic [CW-1:0]            cfg_w_r, cfg_h_r;
  logic [CW-1:0]            eff_w, eff_h;

  logic [CW-1:0]            x1_r, y1_r, x2_r, y2_r;
  logic signed [31:0]       z1_r, z2_r;

  logic [CW-1:0]            a1_r, b1_r, n_r, k_r;
  logic                     steep_r, neg_r;
  logic signed [CW:0]       dm_r;
  logic signed [CW:0]       qm_r;
  logic [CW-1:0]            rm_r, rz_r;
  logic signed [33:0]       dq_r, qz_r;
  logic [CW-1:0]            dr_r;
  logic signed [31:0]       zs_r;

  logic [31:0]              mem [DEPTH];
  logic [31:0]              rd_data_r;
  rast_pkg::out_word_t      out_r;
  rast_pkg::div_res_t       div_res;

  // orient
  logic [CW-1:0]            dx, dy, ma1, ma2, mi1, mi2;
  logic                     steep, swap;
  logic signed [32:0]       dz;
  logic signed [31:0]       za, zb;

  // pixel
  logic [CW-1:0]            major, minor, px, py;
  logic [AW-1:0]            pix_addr;
  logic signed [31:0]       z_cur;
  logic                     pass, last;
  logic signed [CW+1:0]     tm;
  logic [CW:0]              tz;

  function automatic logic [CW-1:0] eff_dim(input logic [CW-1:0] r, input int maxv);
    int v;
    v = int'(r);
    if (v < 1) v = 1;
    if (v > maxv) v = maxv;
    return CW'(v);
  endfunction

  function automatic logic [CW-1:0] clampc(input logic signed [15:0] v,
                                            input logic [CW-1:0] dim);
    logic [CW-1:0] hi;
    hi = dim - 1'b1;
    if (v < 0) return '0;
    if (v > $signed({{(16-CW){1'b0}}, hi})) return hi;
    return v[CW-1:0];
  endfunction

  assign eff_w = eff_dim(cfg_w_r, MAX_WIDTH);
  assign eff_h = eff_dim(cfg_h_r, MAX_HEIGHT);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_w_r <= 7'd64;
      cfg_h_r <= 7'd64;
    end else if (cfg_valid) begin
      case (cfg_index)
        rast_pkg::REG_ACTIVE_WIDTH:  cfg_w_r <= cfg_data;
        rast_pkg::REG_ACTIVE_HEIGHT: cfg_h_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // ordering and swap
  always_comb begin
    dx    = (x1_r > x2_r) ? x1_r - x2_r : x2_r - x1_r;
    dy    = (y1_r > y2_r) ? y1_r - y2_r : y2_r - y1_r;
    steep = dx < dy;
    ma1   = steep ? y1_r : x1_r;
    ma2   = steep ? y2_r : x2_r;
    mi1   = steep ? x1_r : y1_r;
    mi2   = steep ? x2_r : y2_r;
    swap  = ma1 > ma2;
    if (swap) begin
      {ma1, ma2} = {ma2, ma1};
      {mi1, mi2} = {mi2, mi1};
      za = z2_r;
      zb = z1_r;
    end else begin
      za = z1_r;
      zb = z2_r;
    end
    dz = 33'(zb) - 33'(za);
  end

  rast_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (state_r == ST_ORIENT && ma2 != ma1),
    .dividend (dz[32] ? 33'(-dz) : 33'(dz)),
    .divisor  (ma2 - ma1),
    .res      (div_res)
  );

  // current pixel
  always_comb begin
    major    = a1_r + k_r;
    minor    = CW'(qm_r + $signed({1'b0, b1_r}));
    px       = steep_r ? minor : major;
    py       = steep_r ? major : minor;
    pix_addr = AW'(py * MAX_WIDTH) + AW'(px);
    z_cur    = 32'(34'(zs_r) + qz_r);
    pass     = 34'(z_cur) >= 34'(signed'(rd_data_r)) - rast_pkg::DEPTH_SLACK;
    last     = k_r == n_r - 1'b1;
    tm       = $signed({2'b00, rm_r}) + (CW+2)'(dm_r);
    tz       = {1'b0, rz_r} + {1'b0, dr_r};
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLR:    if (clr_r == AW'(DEPTH - 1)) state_nxt = ST_IDLE;
      ST_IDLE:   if (in_valid) state_nxt = ST_ORIENT;
      ST_ORIENT: state_nxt = (ma2 == ma1) ? ST_IDLE : ST_DIV;
      ST_DIV:    if (div_res.done) state_nxt = ST_FIX;
      ST_FIX:    state_nxt = ST_RD;
      ST_RD:     state_nxt = ST_CMP;
      ST_CMP:    state_nxt = ST_OUT;
      ST_OUT:    if (out_ready) state_nxt = out_r.last ? ST_IDLE : ST_RD;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLR;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLR) clr_r <= clr_r + 1'b1;
    end
  end

  // depth memory
  always_ff @(posedge clk) begin
    if (state_r == ST_CLR) mem[clr_r] <= rast_pkg::DEPTH_MIN;
    else if (state_r == ST_CMP && pass) mem[pix_addr] <= z_cur;
    rd_data_r <= mem[pix_addr];
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        x1_r <= clampc(in_data.x_start, eff_w);
        y1_r <= clampc(in_data.y_start, eff_h);
        x2_r <= clampc(in_data.x_end, eff_w);
        y2_r <= clampc(in_data.y_end, eff_h);
        z1_r <= in_data.z_start;
        z2_r <= in_data.z_end;
      end
      ST_ORIENT: begin
        a1_r    <= ma1;
        b1_r    <= mi1;
        n_r     <= ma2 - ma1;
        steep_r <= steep;
        dm_r    <= $signed({1'b0, mi2}) - $signed({1'b0, mi1});
        zs_r    <= za;
        neg_r   <= dz[32];
      end
      ST_FIX: begin
        // floor division of the depth span by n
        if (!neg_r) begin
          dq_r <= 34'({1'b0, div_res.quo});
          dr_r <= div_res.rem;
        end else if (div_res.rem == '0) begin
          dq_r <= -34'({1'b0, div_res.quo});
          dr_r <= '0;
        end else begin
          dq_r <= -34'({1'b0, div_res.quo}) - 34'sd1;
          dr_r <= n_r - div_res.rem;
        end
        k_r  <= '0;
        qm_r <= '0;
        rm_r <= '0;
        qz_r <= '0;
        rz_r <= '0;
      end
      ST_CMP: begin
        out_r.pixel_x     <= 6'(px);
        out_r.pixel_y     <= 6'(py);
        out_r.pixel_depth <= z_cur;
        out_r.written     <= pass;
        out_r.last        <= last;
        k_r <= k_r + 1'b1;
        if (tm >= $signed({2'b00, n_r})) begin
          rm_r <= CW'(tm - $signed({2'b00, n_r}));
          qm_r <= qm_r + 1'b1;
        end else if (tm < 0) begin
          rm_r <= CW'(tm + $signed({2'b00, n_r}));
          qm_r <= qm_r - 1'b1;
        end else begin
          rm_r <= CW'(tm);
        end
        if (tz >= {1'b0, n_r}) begin
          rz_r <= CW'(tz - {1'b0, n_r});
          qz_r <= qz_r + dq_r + 34'sd1;
        end else begin
          rz_r <= CW'(tz);
          qz_r <= qz_r + dq_r;
        end
      end
      default: ;
    endcase
  end

  assign in_ready  = state_r == ST_IDLE;
  assign out_valid = state_r == ST_OUT;
  assign out_data  = out_r;

  assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> !in_ready)
    else $error("input taken while a pixel word is pending");

  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_RD |=> state_r == ST_CMP)
    else $error("depth read not followed by test");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_data.last |=> in_ready)
    else $error("sequencer not idle after last pixel");

  assert property (@(posedge clk) disable iff (!rst_n)
    div_res.done |-> state_r == ST_DIV)
    else $error("divider finished outside its wait state");

endmodule

`default_nettype wire
